// ===== rtl/npcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types and constants of the NAND page command sequencer: geometry,
// opcodes, bus cycle codes and the job descriptor passed from front to back.
// ----------------------------------------------------------------------------
package npcs_pkg;

	localparam int PAGE_BYTES      = 2048;
	localparam int PAGES_PER_BLOCK = 64;
	localparam int COL_W           = $clog2(PAGE_BYTES);
	localparam int PAGE_W          = 21;
	localparam int BLK_W           = $clog2(PAGE_BYTES * PAGES_PER_BLOCK);
	localparam logic [31:0] BLK_BYTES = 32'(PAGE_BYTES * PAGES_PER_BLOCK);
	localparam int NUM_SLOTS       = 16;

	localparam logic [7:0] CMD_READ      = 8'h00;
	localparam logic [7:0] CMD_READ_GO   = 8'h30;
	localparam logic [7:0] CMD_PROG      = 8'h80;
	localparam logic [7:0] CMD_PROG_GO   = 8'h10;
	localparam logic [7:0] CMD_ERASE     = 8'h60;
	localparam logic [7:0] CMD_ERASE_GO  = 8'hD0;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_PROG  = 2'd1,
		KIND_ERASE = 2'd2,
		KIND_STEP  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_PROG  = 2'd2,
		MODE_ERASE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CY_SEL   = 3'd0,
		CY_DESEL = 3'd1,
		CY_CMD   = 3'd2,
		CY_ADDR  = 3'd3,
		CY_WDATA = 3'd4,
		CY_RDATA = 3'd5,
		CY_WAIT  = 3'd6,
		CY_ERR   = 3'd7
	} cycle_t;

	// bus word slots, emitted lowest first
	typedef enum logic [3:0] {
		SLOT_PRE_DESEL = 4'd0,
		SLOT_ERR       = 4'd1,
		SLOT_SEL       = 4'd2,
		SLOT_CMD_A     = 4'd3,
		SLOT_COL_LO    = 4'd4,
		SLOT_COL_HI    = 4'd5,
		SLOT_ROW_LO    = 4'd6,
		SLOT_ROW_MID   = 4'd7,
		SLOT_ROW_HI    = 4'd8,
		SLOT_CMD_B     = 4'd9,
		SLOT_WAIT_A    = 4'd10,
		SLOT_RDATA     = 4'd11,
		SLOT_WDATA     = 4'd12,
		SLOT_CMD_C     = 4'd13,
		SLOT_WAIT_B    = 4'd14,
		SLOT_FIN       = 4'd15
	} slot_t;

	typedef struct packed {
		logic [NUM_SLOTS-1:0] mask;
		logic [7:0]           cmd_a;
		logic [7:0]           cmd_b;
		logic [COL_W-1:0]     column;
		logic [PAGE_W-1:0]    page;
		logic [7:0]           data;
	} desc_t;

endpackage
`default_nettype wire

// ===== rtl/nand_page_command_sequencer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nand_page_command_sequencer_unit
// Large-page NAND read/program/erase command sequencer.
// ----------------------------------------------------------------------------
// Each request word (start read, start program, start erase, or step) yields
// one to ten bus words on the output, one per clock while the bus side takes
// them; the bus sequencer emitting a single word a cycle sets the rate.
// Request words are taken back to back while the two-entry descriptor
// queue has room.
module nand_page_command_sequencer_unit import npcs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output      logic        req_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] address,
	input  wire logic [31:0] length,
	input  wire logic [7:0]  data_byte,
	output      logic        bus_valid,
	input  wire logic        bus_ready,
	output      logic [2:0]  cycle,
	output      logic [7:0]  value,
	output      logic        last,
	output      logic        done_res
);

	logic  push_valid;
	logic  push_ready;
	desc_t push_desc;
	logic  pop_valid;
	logic  pop_ready;
	desc_t pop_desc;

	npcs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.kind       (kind),
		.address    (address),
		.length     (length),
		.data_byte  (data_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc)
	);

	npcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_desc   (pop_desc)
	);

	npcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_desc  (pop_desc),
		.bus_valid (bus_valid),
		.bus_ready (bus_ready),
		.cycle     (cycle),
		.value     (value),
		.last      (last),
		.done_res  (done_res)
	);

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		bus_valid && done_res |-> last)
		else $error("done word not last");

	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		bus_valid && (cycle == CY_ERR) |-> done_res && last)
		else $error("error word does not end item");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		bus_valid && ((cycle == CY_SEL) || (cycle == CY_DESEL) || (cycle == CY_WAIT)
		|| (cycle == CY_RDATA) || (cycle == CY_ERR)) |-> (value == 8'h00))
		else $error("non-zero value on control word");

endmodule
`default_nettype wire

// ===== rtl/npcs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_front
// Accepts request words, tracks the operation state and turns each word
// into a job descriptor listing the bus word slots it causes.
// ----------------------------------------------------------------------------
module npcs_front import npcs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output      logic        req_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] address,
	input  wire logic [31:0] length,
	input  wire logic [7:0]  data_byte,
	output      logic        push_valid,
	input  wire logic        push_ready,
	output      desc_t       push_desc
);

	mode_t             mode_q, mode_n;
	logic [PAGE_W-1:0] page_q, page_n;
	logic [COL_W-1:0]  col_q, col_n;
	logic [31:0]       rem_q, rem_n;
	logic              hdr_q, hdr_n;

	kind_t       kind_c;
	logic        accept;
	logic        erase_bad;
	logic        last_byte;
	logic        page_end;
	logic [31:0] erase_rem;
	logic        erase_last;

	assign kind_c     = kind_t'(kind);
	assign accept     = req_valid && push_ready;
	assign req_ready  = push_ready;
	assign push_valid = req_valid;

	assign erase_bad  = (kind_c == KIND_ERASE) && ((length == 32'd0)
		|| (length[BLK_W-1:0] != '0) || (address[BLK_W-1:0] != '0));
	assign last_byte  = (rem_q == 32'd1);
	assign page_end   = (col_q == {COL_W{1'b1}});
	assign erase_rem  = (rem_q >= BLK_BYTES) ? (rem_q - BLK_BYTES) : 32'd0;
	assign erase_last = (erase_rem == 32'd0);

	// next state
	always_comb begin
		mode_n = mode_q;
		page_n = page_q;
		col_n  = col_q;
		rem_n  = rem_q;
		hdr_n  = hdr_q;
		if (kind_c != KIND_STEP) begin
			mode_n = MODE_IDLE;
			hdr_n  = 1'b0;
			if (!erase_bad) begin
				page_n = PAGE_W'(address >> COL_W);
				col_n  = address[COL_W-1:0];
				rem_n  = length;
				if (length != 32'd0) begin
					unique case (kind_c)
						KIND_READ: mode_n = MODE_READ;
						KIND_PROG: mode_n = MODE_PROG;
						default:   mode_n = MODE_ERASE;
					endcase
				end
			end
		end else begin
			unique case (mode_q)
				MODE_IDLE: ;
				MODE_READ, MODE_PROG: begin
					col_n = col_q + COL_W'(1);
					rem_n = rem_q - 32'd1;
					hdr_n = 1'b1;
					if (last_byte) begin
						mode_n = MODE_IDLE;
						hdr_n  = 1'b0;
					end else if (page_end) begin
						page_n = page_q + PAGE_W'(1);
						hdr_n  = 1'b0;
					end
				end
				MODE_ERASE: begin
					rem_n  = erase_rem;
					page_n = page_q + PAGE_W'(PAGES_PER_BLOCK);
					if (erase_last) begin
						mode_n = MODE_IDLE;
						hdr_n  = 1'b0;
					end
				end
			endcase
		end
	end

	// descriptor
	always_comb begin
		push_desc        = '0;
		push_desc.column = col_q;
		push_desc.page   = page_q;
		push_desc.data   = data_byte;
		if (kind_c != KIND_STEP) begin
			push_desc.mask[SLOT_PRE_DESEL] = (mode_q != MODE_IDLE);
			if (erase_bad) begin
				push_desc.mask[SLOT_ERR] = 1'b1;
			end else begin
				push_desc.mask[SLOT_SEL] = 1'b1;
				push_desc.mask[SLOT_FIN] = (length == 32'd0);
			end
		end else begin
			unique case (mode_q)
				MODE_IDLE: push_desc.mask[SLOT_ERR] = 1'b1;
				MODE_READ: begin
					push_desc.cmd_a = CMD_READ;
					push_desc.cmd_b = CMD_READ_GO;
					if (!hdr_q) begin
						push_desc.mask[SLOT_CMD_A]   = 1'b1;
						push_desc.mask[SLOT_COL_LO]  = 1'b1;
						push_desc.mask[SLOT_COL_HI]  = 1'b1;
						push_desc.mask[SLOT_ROW_LO]  = 1'b1;
						push_desc.mask[SLOT_ROW_MID] = 1'b1;
						push_desc.mask[SLOT_ROW_HI]  = 1'b1;
						push_desc.mask[SLOT_CMD_B]   = 1'b1;
						push_desc.mask[SLOT_WAIT_A]  = 1'b1;
					end
					push_desc.mask[SLOT_RDATA] = 1'b1;
					push_desc.mask[SLOT_FIN]   = last_byte;
				end
				MODE_PROG: begin
					push_desc.cmd_a = CMD_PROG;
					if (!hdr_q) begin
						push_desc.mask[SLOT_CMD_A]   = 1'b1;
						push_desc.mask[SLOT_COL_LO]  = 1'b1;
						push_desc.mask[SLOT_COL_HI]  = 1'b1;
						push_desc.mask[SLOT_ROW_LO]  = 1'b1;
						push_desc.mask[SLOT_ROW_MID] = 1'b1;
						push_desc.mask[SLOT_ROW_HI]  = 1'b1;
					end
					push_desc.mask[SLOT_WDATA]  = 1'b1;
					push_desc.mask[SLOT_CMD_C]  = last_byte || page_end;
					push_desc.mask[SLOT_WAIT_B] = last_byte || page_end;
					push_desc.mask[SLOT_FIN]    = last_byte;
				end
				MODE_ERASE: begin
					push_desc.cmd_a = CMD_ERASE;
					push_desc.cmd_b = CMD_ERASE_GO;
					push_desc.mask[SLOT_CMD_A]   = 1'b1;
					push_desc.mask[SLOT_ROW_LO]  = 1'b1;
					push_desc.mask[SLOT_ROW_MID] = 1'b1;
					push_desc.mask[SLOT_ROW_HI]  = 1'b1;
					push_desc.mask[SLOT_CMD_B]   = 1'b1;
					push_desc.mask[SLOT_WAIT_A]  = 1'b1;
					push_desc.mask[SLOT_FIN]     = erase_last;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			page_q <= '0;
			col_q  <= '0;
			rem_q  <= '0;
			hdr_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_n;
			page_q <= page_n;
			col_q  <= col_n;
			rem_q  <= rem_n;
			hdr_q  <= hdr_n;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/npcs_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_queue
// Two-entry descriptor queue decoupling the front from the bus sequencer.
// ----------------------------------------------------------------------------
module npcs_queue import npcs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output      logic  push_ready,
	input  wire desc_t push_desc,
	output      logic  pop_valid,
	input  wire logic  pop_ready,
	output      desc_t pop_desc
);

	desc_t      entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_desc   = entry_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/npcs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_back
// Bus sequencer: walks the slots of the current descriptor, one bus word per
// clock while the bus side takes them, into a registered output.
// ----------------------------------------------------------------------------
module npcs_back import npcs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pop_valid,
	output      logic        pop_ready,
	input  wire desc_t       pop_desc,
	output      logic        bus_valid,
	input  wire logic        bus_ready,
	output      logic [2:0]  cycle,
	output      logic [7:0]  value,
	output      logic        last,
	output      logic        done_res
);

	desc_t                work_q;
	logic [NUM_SLOTS-1:0] mask_q;
	logic                 valid_q;
	cycle_t               cycle_q;
	logic [7:0]           value_q;
	logic                 last_q;
	logic                 done_q;

	slot_t                slot;
	logic [NUM_SLOTS-1:0] mask_rest;
	logic                 emit;
	logic                 load;
	cycle_t               cy_c;
	logic [7:0]           val_c;
	logic                 done_c;
	logic [15:0]          col_ext;
	logic [23:0]          page_ext;

	always_comb begin
		slot = SLOT_FIN;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				slot = slot_t'(i);
			end
		end
	end

	assign mask_rest = mask_q & ~(NUM_SLOTS'(1) << slot);
	assign emit      = (mask_q != '0) && (!valid_q || bus_ready);
	assign load      = (mask_q == '0) || (emit && (mask_rest == '0));
	assign pop_ready = load;
	assign col_ext   = 16'(work_q.column);
	assign page_ext  = 24'(work_q.page);

	always_comb begin
		cy_c   = CY_ADDR;
		val_c  = 8'h00;
		done_c = 1'b0;
		unique case (slot)
			SLOT_PRE_DESEL: cy_c = CY_DESEL;
			SLOT_ERR: begin
				cy_c   = CY_ERR;
				done_c = 1'b1;
			end
			SLOT_SEL: cy_c = CY_SEL;
			SLOT_CMD_A: begin
				cy_c  = CY_CMD;
				val_c = work_q.cmd_a;
			end
			SLOT_COL_LO:  val_c = col_ext[7:0];
			SLOT_COL_HI:  val_c = col_ext[15:8];
			SLOT_ROW_LO:  val_c = page_ext[7:0];
			SLOT_ROW_MID: val_c = page_ext[15:8];
			SLOT_ROW_HI:  val_c = page_ext[23:16];
			SLOT_CMD_B: begin
				cy_c  = CY_CMD;
				val_c = work_q.cmd_b;
			end
			SLOT_WAIT_A: cy_c = CY_WAIT;
			SLOT_RDATA:  cy_c = CY_RDATA;
			SLOT_WDATA: begin
				cy_c  = CY_WDATA;
				val_c = work_q.data;
			end
			SLOT_CMD_C: begin
				cy_c  = CY_CMD;
				val_c = CMD_PROG_GO;
			end
			SLOT_WAIT_B: cy_c = CY_WAIT;
			SLOT_FIN: begin
				cy_c   = CY_DESEL;
				done_c = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			work_q <= pop_desc;
		end
		if (emit) begin
			cycle_q <= cy_c;
			value_q <= val_c;
			last_q  <= (mask_rest == '0);
			done_q  <= done_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= pop_valid ? pop_desc.mask : '0;
			end else if (emit) begin
				mask_q <= mask_rest;
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (bus_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign bus_valid = valid_q;
	assign cycle     = cycle_q;
	assign value     = value_q;
	assign last      = last_q;
	assign done_res  = done_q;

endmodule
`default_nettype wire
